// ===== src/hbd_pkg.sv =====
// http body deframer package: parse phases, error codes, character codes,
// configuration register indexes and shared structs
// no dependencies
`default_nettype none

package hbd_pkg;

    localparam int unsigned MAX_LINE     = 8192;
    localparam int unsigned MAX_TRAILERS = 32;
    localparam int unsigned LINE_W       = $clog2(MAX_LINE + 2);
    localparam int unsigned TRAIL_W      = $clog2(MAX_TRAILERS + 2);

    localparam logic [63:0] MAX_BODY_RESET = 64'd67108864;

    localparam logic [7:0] CH_CR   = 8'h0d;
    localparam logic [7:0] CH_LF   = 8'h0a;
    localparam logic [7:0] CH_SEMI = 8'h3b;

    typedef enum logic [3:0] {
        PH_DONE   = 4'd0,
        PH_CLEN   = 4'd1,
        PH_UNTIL  = 4'd2,
        PH_SZ     = 4'd3,
        PH_SZ_CR  = 4'd4,
        PH_HEX    = 4'd5,
        PH_HEX_CR = 4'd6,
        PH_EXT    = 4'd7,
        PH_EXT_CR = 4'd8,
        PH_DATA   = 4'd9,
        PH_DCR    = 4'd10,
        PH_DLF    = 4'd11,
        PH_TR     = 4'd12,
        PH_TR_CR  = 4'd13,
        PH_TRL    = 4'd14,
        PH_TRL_CR = 4'd15
    } phase_t;

    typedef enum logic [1:0] {
        ERR_NONE = 2'd0,
        ERR_IO   = 2'd1,
        ERR_BAD  = 2'd2,
        ERR_BIG  = 2'd3
    } err_t;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_CLEN  = 2'd1,
        MODE_CHUNK = 2'd2,
        MODE_UNTIL = 2'd3
    } mode_t;

    localparam logic [1:0] REG_FRAMING  = 2'd0;
    localparam logic [1:0] REG_CLEN     = 2'd1;
    localparam logic [1:0] REG_MAX_BODY = 2'd2;

    typedef struct packed {
        logic        we;
        logic [1:0]  index;
        logic [63:0] wdata;
    } cfg_wr_t;

    typedef struct packed {
        logic [1:0] error_code;
        logic       body_done;
        logic [7:0] payload_byte;
        logic       payload_valid;
    } result_t;

    // bit 4 set for a hex digit, value in the low bits
    function automatic logic [4:0] hex_digit(input logic [7:0] b);
        logic [4:0] r;
        r = 5'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            r = {1'b1, 4'(b - 8'h30)};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            r = {1'b1, 4'(b - 8'h57)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            r = {1'b1, 4'(b - 8'h37)};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/hbd_core.sv =====
// http body deframer parser core: configuration registers, parse state and
// the per-beat update; uses hbd_pkg
`default_nettype none

module hbd_core (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire hbd_pkg::cfg_wr_t cfg,
    input  wire logic            step_en,
    input  wire logic            kind,
    input  wire logic [7:0]      rx_byte,
    output hbd_pkg::result_t     result
);

    logic [1:0]                 mode_reg;
    logic [63:0]                clen_reg;
    logic [63:0]                max_reg;
    hbd_pkg::phase_t            phase_reg, phase_next;
    logic [63:0]                chunk_reg, chunk_next;
    logic [63:0]                len_reg, len_next;
    logic [63:0]                total_reg, total_next;
    logic                       ovf_reg, ovf_next;
    logic [hbd_pkg::LINE_W-1:0] line_reg, line_next;
    logic [hbd_pkg::TRAIL_W-1:0] trail_reg, trail_next;
    logic [1:0]                 err_reg, err_next;

    logic [1:0]  mode_new;
    logic [63:0] clen_new;
    logic [63:0] max_new;
    logic        restart;

    // shared body limit check
    logic        acct_one;
    logic [63:0] acct_n;
    logic        too_big;

    logic [hbd_pkg::LINE_W-1:0] line_inc;
    logic                       line_over;
    logic [hbd_pkg::TRAIL_W-1:0] trail_inc;
    logic [4:0]                 hexd;
    logic                       valid;

    assign restart = cfg.we && (cfg.index == hbd_pkg::REG_FRAMING ||
                                cfg.index == hbd_pkg::REG_CLEN ||
                                cfg.index == hbd_pkg::REG_MAX_BODY);

    always_comb begin
        mode_new = mode_reg;
        clen_new = clen_reg;
        max_new  = max_reg;
        if (cfg.we) begin
            unique case (cfg.index)
                hbd_pkg::REG_FRAMING:  mode_new = cfg.wdata[1:0];
                hbd_pkg::REG_CLEN:     clen_new = cfg.wdata;
                hbd_pkg::REG_MAX_BODY: max_new  = cfg.wdata;
                default: ;
            endcase
        end
    end

    function automatic hbd_pkg::phase_t start_phase(input logic [1:0] m,
                                                    input logic [63:0] cl);
        hbd_pkg::phase_t p;
        unique case (m)
            hbd_pkg::MODE_CLEN:  p = (cl == 64'd0) ? hbd_pkg::PH_DONE : hbd_pkg::PH_CLEN;
            hbd_pkg::MODE_CHUNK: p = hbd_pkg::PH_SZ;
            hbd_pkg::MODE_UNTIL: p = hbd_pkg::PH_UNTIL;
            default:             p = hbd_pkg::PH_DONE;
        endcase
        return p;
    endfunction

    assign acct_one  = (phase_reg == hbd_pkg::PH_CLEN) || (phase_reg == hbd_pkg::PH_UNTIL);
    assign acct_n    = acct_one ? 64'd1 : chunk_reg;
    assign too_big   = (acct_n > max_reg) || (total_reg > (max_reg - acct_n));
    assign line_inc  = (line_reg <= hbd_pkg::LINE_W'(hbd_pkg::MAX_LINE)) ?
                       line_reg + 1'b1 : line_reg;
    assign line_over = line_inc > hbd_pkg::LINE_W'(hbd_pkg::MAX_LINE);
    assign trail_inc = trail_reg + 1'b1;
    assign hexd      = hbd_pkg::hex_digit(rx_byte);

    always_comb begin
        logic            cr;
        logic            is_ext;
        hbd_pkg::phase_t base;
        phase_next = phase_reg;
        chunk_next = chunk_reg;
        len_next   = len_reg;
        total_next = total_reg;
        ovf_next   = ovf_reg;
        line_next  = line_reg;
        trail_next = trail_reg;
        err_next   = err_reg;
        valid      = 1'b0;
        cr         = 1'b0;
        is_ext     = 1'b0;
        base       = phase_reg;

        if (phase_reg == hbd_pkg::PH_DONE) begin
            // ignored
        end else if (kind) begin
            if (phase_reg == hbd_pkg::PH_UNTIL) begin
                phase_next = hbd_pkg::PH_DONE;
            end else begin
                phase_next = hbd_pkg::PH_DONE;
                if (err_reg == hbd_pkg::ERR_NONE) err_next = hbd_pkg::ERR_IO;
            end
        end else if (phase_reg == hbd_pkg::PH_CLEN || phase_reg == hbd_pkg::PH_UNTIL) begin
            if (too_big) begin
                phase_next = hbd_pkg::PH_DONE;
                if (err_reg == hbd_pkg::ERR_NONE) err_next = hbd_pkg::ERR_BIG;
            end else begin
                valid      = 1'b1;
                total_next = total_reg + 64'd1;
                if (phase_reg == hbd_pkg::PH_CLEN) begin
                    len_next = len_reg - 64'd1;
                    if (len_reg == 64'd1) phase_next = hbd_pkg::PH_DONE;
                end
            end
        end else if (phase_reg == hbd_pkg::PH_DATA) begin
            valid      = 1'b1;
            chunk_next = chunk_reg - 64'd1;
            if (chunk_reg == 64'd1) phase_next = hbd_pkg::PH_DCR;
        end else if (phase_reg == hbd_pkg::PH_DCR) begin
            ovf_next   = (rx_byte != hbd_pkg::CH_CR);
            phase_next = hbd_pkg::PH_DLF;
        end else if (phase_reg == hbd_pkg::PH_DLF) begin
            if (ovf_reg || rx_byte != hbd_pkg::CH_LF) begin
                phase_next = hbd_pkg::PH_DONE;
                if (err_reg == hbd_pkg::ERR_NONE) err_next = hbd_pkg::ERR_BAD;
            end else begin
                ovf_next   = 1'b0;
                chunk_next = 64'd0;
                line_next  = '0;
                phase_next = hbd_pkg::PH_SZ;
            end
        end else if (phase_reg >= hbd_pkg::PH_TR) begin
            // trailer lines
            cr = (phase_reg == hbd_pkg::PH_TR_CR) || (phase_reg == hbd_pkg::PH_TRL_CR);
            if (cr && rx_byte == hbd_pkg::CH_LF) begin
                line_next = '0;
                if (phase_reg == hbd_pkg::PH_TR_CR) begin
                    phase_next = hbd_pkg::PH_DONE;
                end else begin
                    trail_next = trail_inc;
                    if (trail_inc > hbd_pkg::TRAIL_W'(hbd_pkg::MAX_TRAILERS)) begin
                        phase_next = hbd_pkg::PH_DONE;
                        if (err_reg == hbd_pkg::ERR_NONE) err_next = hbd_pkg::ERR_BAD;
                    end else begin
                        phase_next = hbd_pkg::PH_TR;
                    end
                end
            end else begin
                base = (cr || phase_reg == hbd_pkg::PH_TRL) ? hbd_pkg::PH_TRL : hbd_pkg::PH_TR;
                line_next = line_inc;
                if (line_over) begin
                    phase_next = hbd_pkg::PH_DONE;
                    if (err_reg == hbd_pkg::ERR_NONE) err_next = hbd_pkg::ERR_BAD;
                end else if (rx_byte == hbd_pkg::CH_CR) begin
                    phase_next = (base == hbd_pkg::PH_TR) ? hbd_pkg::PH_TR_CR
                                                          : hbd_pkg::PH_TRL_CR;
                end else begin
                    phase_next = hbd_pkg::PH_TRL;
                end
            end
        end else begin
            // chunk size line
            cr = (phase_reg == hbd_pkg::PH_SZ_CR) || (phase_reg == hbd_pkg::PH_HEX_CR) ||
                 (phase_reg == hbd_pkg::PH_EXT_CR);
            is_ext = (phase_reg == hbd_pkg::PH_EXT) || (phase_reg == hbd_pkg::PH_EXT_CR);
            if (cr && rx_byte == hbd_pkg::CH_LF) begin
                line_next = '0;
                if (phase_reg == hbd_pkg::PH_SZ_CR || ovf_reg) begin
                    phase_next = hbd_pkg::PH_DONE;
                    if (err_reg == hbd_pkg::ERR_NONE) err_next = hbd_pkg::ERR_BAD;
                end else if (chunk_reg == 64'd0) begin
                    trail_next = '0;
                    phase_next = hbd_pkg::PH_TR;
                end else if (too_big) begin
                    phase_next = hbd_pkg::PH_DONE;
                    if (err_reg == hbd_pkg::ERR_NONE) err_next = hbd_pkg::ERR_BIG;
                end else begin
                    total_next = total_reg + chunk_reg;
                    phase_next = hbd_pkg::PH_DATA;
                end
            end else begin
                if (is_ext) begin
                    base = hbd_pkg::PH_EXT;
                end else if (cr) begin
                    // lone cr before the extension is not a digit
                    ovf_next = 1'b1;
                    base     = hbd_pkg::PH_HEX;
                end
                line_next = line_inc;
                if (line_over) begin
                    phase_next = hbd_pkg::PH_DONE;
                    if (err_reg == hbd_pkg::ERR_NONE) err_next = hbd_pkg::ERR_BAD;
                end else if (base == hbd_pkg::PH_EXT) begin
                    phase_next = (rx_byte == hbd_pkg::CH_CR) ? hbd_pkg::PH_EXT_CR
                                                             : hbd_pkg::PH_EXT;
                end else if (rx_byte == hbd_pkg::CH_SEMI) begin
                    if (base == hbd_pkg::PH_SZ) ovf_next = 1'b1;
                    phase_next = hbd_pkg::PH_EXT;
                end else if (rx_byte == hbd_pkg::CH_CR) begin
                    phase_next = (base == hbd_pkg::PH_SZ) ? hbd_pkg::PH_SZ_CR
                                                          : hbd_pkg::PH_HEX_CR;
                end else begin
                    if (!hexd[4]) begin
                        ovf_next = 1'b1;
                    end else begin
                        if (chunk_reg[63:60] != 4'd0) ovf_next = 1'b1;
                        chunk_next = {chunk_reg[59:0], hexd[3:0]};
                    end
                    phase_next = hbd_pkg::PH_HEX;
                end
            end
        end
    end

    assign result.payload_valid = valid;
    assign result.payload_byte  = valid ? rx_byte : 8'd0;
    assign result.body_done     = (phase_next == hbd_pkg::PH_DONE);
    assign result.error_code    = err_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= hbd_pkg::MODE_NONE;
            clen_reg  <= 64'd0;
            max_reg   <= hbd_pkg::MAX_BODY_RESET;
            phase_reg <= hbd_pkg::PH_DONE;
            chunk_reg <= 64'd0;
            len_reg   <= 64'd0;
            total_reg <= 64'd0;
            ovf_reg   <= 1'b0;
            line_reg  <= '0;
            trail_reg <= '0;
            err_reg   <= hbd_pkg::ERR_NONE;
        end else if (restart) begin
            mode_reg  <= mode_new;
            clen_reg  <= clen_new;
            max_reg   <= max_new;
            phase_reg <= start_phase(mode_new, clen_new);
            chunk_reg <= 64'd0;
            len_reg   <= clen_new;
            total_reg <= 64'd0;
            ovf_reg   <= 1'b0;
            line_reg  <= '0;
            trail_reg <= '0;
            err_reg   <= hbd_pkg::ERR_NONE;
        end else if (step_en) begin
            phase_reg <= phase_next;
            chunk_reg <= chunk_next;
            len_reg   <= len_next;
            total_reg <= total_next;
            ovf_reg   <= ovf_next;
            line_reg  <= line_next;
            trail_reg <= trail_next;
            err_reg   <= err_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/http_body_deframer.sv =====
// http body deframer top level: stream ports, configuration write port and
// the result register; uses hbd_pkg and hbd_core
//
// Takes one beat per clock, either a received body byte or a peer close, and
// returns exactly one result beat for each in the cycle after acceptance. The
// parse state is updated in the same cycle as the beat is accepted, so the
// rate is one beat per cycle; the path that sets the clock is the 64-bit
// body limit check on a chunk size feeding the phase update. A new beat is
// taken whenever the result register is empty or is read in the same cycle;
// while a result waits on m_tready, s_tready is held low.
// Framing is chosen by register 0 (none, content length, chunked, until
// close); a write to registers 0-2 restarts the parser. Errors are sticky and end
// the body: 1 early close, 2 malformed framing, 3 body too large.
`default_nettype none

module http_body_deframer (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // rx_byte
    input  wire logic        s_tuser,   // kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // payload_byte, body_done, error_code, zero fill
    output logic             m_tuser    // payload_valid
);

    hbd_pkg::cfg_wr_t cfg;
    hbd_pkg::result_t result;
    logic             accept;
    logic             m_valid_reg;
    hbd_pkg::result_t m_data_reg;

    assign cfg.we    = cfg_we;
    assign cfg.index = cfg_index;
    assign cfg.wdata = cfg_wdata;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    hbd_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .step_en (accept),
        .kind    (s_tuser),
        .rx_byte (s_tdata),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_data_reg <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_data_reg.payload_valid;
    assign m_tdata  = {5'd0, m_data_reg.error_code, m_data_reg.body_done,
                       m_data_reg.payload_byte};

`ifndef NO_ASSERTIONS
    // every accepted beat shows up as a result on the next cycle
    a_accept_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> m_tvalid)
        else $error("accepted beat gave no result");

    // a payload beat never carries an error
    a_payload_no_err: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[10:9] == hbd_pkg::ERR_NONE))
        else $error("payload beat with error");

    // an error always ends the body
    a_err_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[10:9] != hbd_pkg::ERR_NONE) |-> m_tdata[8])
        else $error("error without body done");

    // non-payload beats carry a zero byte
    a_zero_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata[7:0] == 8'd0))
        else $error("dropped beat with nonzero byte");
`endif

endmodule

`default_nettype wire
